// ----- sv/oledvf_pkg.sv -----
// Shared types and constants for the OLED viewport byte framer.
`timescale 1ns / 1ps

package oledvf_pkg;

   // Field widths of the panel coordinates
   localparam int COL_W    = 7;
   localparam int PAGE_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int COL_SPAN  = 1 << COL_W;
   localparam int PAGE_SPAN = 1 << PAGE_W;

   // Control bytes that open a command or a data run on the bus
   localparam logic [BYTE_W-1:0] CTRL_CMD  = 8'h80;
   localparam logic [BYTE_W-1:0] CTRL_DATA = 8'h40;

   // Request type codes on the input item
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_SLOT    = 2'd1;
   localparam logic [1:0] REQ_FAIL    = 2'd2;

   // Register indexes and reset values
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_CMD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_CMD   = 1'd1;
   localparam logic [BYTE_W-1:0] COLUMN_CMD_RESET = 8'd33;
   localparam logic [BYTE_W-1:0] PAGE_CMD_RESET   = 8'd34;

   // Depth of the queue between front and back
   localparam int CMD_FIFO_DEPTH = 2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [COL_W-1:0]  win_min_col;
      logic [COL_W-1:0]  win_max_col;
      logic [PAGE_W-1:0] win_min_page;
      logic [PAGE_W-1:0] win_max_page;
      logic [BYTE_W-1:0] pixel_byte;
      logic              pixel_avail;
   } req_item_type;

   typedef struct packed {
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              hold_bus;
      logic              byte_is_pixel;
      logic [COL_W-1:0]  pixel_col;
      logic [PAGE_W-1:0] pixel_page;
      logic              req_finished;
      logic              start_transfer;
      logic              enqueue_dropped;
   } rsp_item_type;

   typedef struct packed {
      logic [COL_W-1:0]  min_col;
      logic [COL_W-1:0]  max_col;
      logic [PAGE_W-1:0] min_page;
      logic [PAGE_W-1:0] max_page;
   } window_type;

   // Classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_SLOT    = 2'd1,
      OP_FAIL    = 2'd2,
      OP_IGNORE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      window_type        win;
      logic [BYTE_W-1:0] pixel_byte;
      logic              pixel_avail;
   } cmd_type;

   // Handshake between front stage and command queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } front_out_type;

endpackage

// ----- sv/oledvf_cmd_fifo.sv -----
// Short command queue between the front and back parts of the framer.
`timescale 1ns / 1ps

module oledvf_cmd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop_en,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push_en && !full;
   assign do_pop    = pop_en && not_empty;
   assign pop_data  = store_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/oledvf_front.sv -----
// Front part: accepts input items, classifies them and feeds the command queue.
`timescale 1ns / 1ps

module oledvf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  oledvf_pkg::req_item_type req_item,
   output oledvf_pkg::front_out_type to_queue,
   input  logic                   queue_full
);

   logic                 hold_valid_ff, hold_valid_in;
   oledvf_pkg::cmd_type  hold_cmd_ff, hold_cmd_in;
   oledvf_pkg::cmd_type  classified;
   logic                 accept, hand_off;

   assign full     = hold_valid_ff && queue_full;
   assign accept   = push && !full;
   assign hand_off = hold_valid_ff && !queue_full;

   assign to_queue.valid = hold_valid_ff;
   assign to_queue.cmd   = hold_cmd_ff;

   // Decode the request type and pack the window fields
   always_comb begin
      classified.win.min_col  = req_item.win_min_col;
      classified.win.max_col  = req_item.win_max_col;
      classified.win.min_page = req_item.win_min_page;
      classified.win.max_page = req_item.win_max_page;
      classified.pixel_byte   = req_item.pixel_byte;
      classified.pixel_avail  = req_item.pixel_avail;
      case (req_item.req_type)
         oledvf_pkg::REQ_ENQUEUE: classified.op = oledvf_pkg::OP_ENQUEUE;
         oledvf_pkg::REQ_SLOT:    classified.op = oledvf_pkg::OP_SLOT;
         oledvf_pkg::REQ_FAIL:    classified.op = oledvf_pkg::OP_FAIL;
         default:                 classified.op = oledvf_pkg::OP_IGNORE;
      endcase
   end

   // One holding stage in front of the queue
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = classified;
      end else if (hand_off) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

// ----- sv/oledvf_back.sv -----
// Back part: request ring, address sequencer, pixel cursor and result register.
`timescale 1ns / 1ps

module oledvf_back #(
   parameter int QUEUE_DEPTH = 4,
   parameter int NUM_COLUMNS = 128,
   parameter int NUM_PAGES   = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  oledvf_pkg::cmd_type      cmd,
   output logic                     cmd_pop,
   input  logic                     csr_wr_en,
   input  logic [oledvf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [oledvf_pkg::BYTE_W-1:0]    csr_wdata,
   output logic                     empty,
   input  logic                     pop,
   output oledvf_pkg::rsp_item_type rsp_item
);

   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = oledvf_pkg::COL_W;
   localparam int PGW = oledvf_pkg::PAGE_W;
   localparam int BW = oledvf_pkg::BYTE_W;

   typedef enum logic [2:0] {
      PH_NONE     = 3'd0,
      PH_COL_CMD  = 3'd1,
      PH_COL_MIN  = 3'd2,
      PH_COL_MAX  = 3'd3,
      PH_PAGE_CMD = 3'd4,
      PH_PAGE_MIN = 3'd5,
      PH_PAGE_MAX = 3'd6,
      PH_DONE     = 3'd7
   } phase_type;

   logic [BW-1:0]          col_code_ff, col_code_in;
   logic [BW-1:0]          page_code_ff, page_code_in;
   oledvf_pkg::window_type slot_win_ff [QUEUE_DEPTH];
   oledvf_pkg::window_type slot_win_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] busy_ff, busy_in;
   logic [HW-1:0]          head_ff, head_in;
   oledvf_pkg::window_type panel_ff, panel_in;
   logic [CW-1:0]          cur_col_ff, cur_col_in;
   logic [PGW-1:0]         cur_page_ff, cur_page_in;
   phase_type              phase_ff, phase_in;
   logic                   addr_ctrl_ff, addr_ctrl_in;
   logic [BW-1:0]          pending_ff, pending_in;
   logic                   data_ctrl_ff, data_ctrl_in;
   logic                   covered_ff, covered_in;
   logic                   active_ff, active_in;
   logic                   out_valid_ff, out_valid_in;
   oledvf_pkg::rsp_item_type out_item_ff, out_item_in;

   oledvf_pkg::rsp_item_type res;
   oledvf_pkg::window_type   w;
   logic                     exec;
   logic                     col_match, page_match;
   logic                     found;
   logic [HW-1:0]            free_idx;
   logic [HW:0]              probe;
   logic                     addr_hit;
   logic [BW-1:0]            addr_cmd;
   logic                     retire;

   // Wrapped increments of the cursor, worked out at elaboration
   logic [CW-1:0]  col_inc_tbl  [oledvf_pkg::COL_SPAN];
   logic [PGW-1:0] page_inc_tbl [oledvf_pkg::PAGE_SPAN];

   for (genvar g = 0; g < oledvf_pkg::COL_SPAN; g++) begin : g_col_tbl
      assign col_inc_tbl[g] = CW'((g + 1) % NUM_COLUMNS);
   end
   for (genvar g = 0; g < oledvf_pkg::PAGE_SPAN; g++) begin : g_page_tbl
      assign page_inc_tbl[g] = PGW'((g + 1) % NUM_PAGES);
   end

   assign exec     = cmd_valid && (!out_valid_ff || pop);
   assign cmd_pop  = exec;
   assign empty    = !out_valid_ff;
   assign rsp_item = out_item_ff;

   assign w = slot_win_ff[head_ff];
   assign col_match = (panel_ff.min_col == w.min_col) && (panel_ff.max_col == w.max_col) &&
                      (cur_col_ff == w.min_col);
   assign page_match = (panel_ff.min_page == w.min_page) &&
                       (panel_ff.max_page == w.max_page) && (cur_page_ff == w.min_page);

   // Free slot search from the head; lowest offset wins
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      probe    = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         probe = (HW+1)'(head_ff) + (HW+1)'(i);
         if (probe >= (HW+1)'(QUEUE_DEPTH)) begin
            probe = probe - (HW+1)'(QUEUE_DEPTH);
         end
         if (!busy_ff[probe[HW-1:0]]) begin
            found    = 1'b1;
            free_idx = probe[HW-1:0];
         end
      end
   end

   // Address sequencer: next command byte, skipping windows already set
   always_comb begin
      addr_hit = 1'b0;
      addr_cmd = '0;
      phase_in = phase_ff;
      case (phase_ff)
         PH_NONE: begin
            if (!col_match) begin
               addr_hit = 1'b1;
               addr_cmd = col_code_ff;
               phase_in = PH_COL_MIN;
            end else if (!page_match) begin
               addr_hit = 1'b1;
               addr_cmd = page_code_ff;
               phase_in = PH_PAGE_MIN;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_COL_CMD: begin
            addr_hit = 1'b1;
            addr_cmd = col_code_ff;
            phase_in = PH_COL_MIN;
         end
         PH_COL_MIN: begin
            addr_hit = 1'b1;
            addr_cmd = BW'(w.min_col);
            phase_in = PH_COL_MAX;
         end
         PH_COL_MAX: begin
            addr_hit = 1'b1;
            addr_cmd = BW'(w.max_col);
            phase_in = PH_PAGE_CMD;
         end
         PH_PAGE_CMD: begin
            if (!page_match) begin
               addr_hit = 1'b1;
               addr_cmd = page_code_ff;
               phase_in = PH_PAGE_MIN;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_PAGE_MIN: begin
            addr_hit = 1'b1;
            addr_cmd = BW'(w.min_page);
            phase_in = PH_PAGE_MAX;
         end
         PH_PAGE_MAX: begin
            addr_hit = 1'b1;
            addr_cmd = BW'(w.max_page);
            phase_in = PH_DONE;
         end
         default: begin
            addr_hit = 1'b0;
         end
      endcase
   end

   // Execute one command and build its result
   always_comb begin
      col_code_in  = col_code_ff;
      page_code_in = page_code_ff;
      slot_win_in  = slot_win_ff;
      busy_in      = busy_ff;
      head_in      = head_ff;
      panel_in     = panel_ff;
      cur_col_in   = cur_col_ff;
      cur_page_in  = cur_page_ff;
      addr_ctrl_in = addr_ctrl_ff;
      pending_in   = pending_ff;
      data_ctrl_in = data_ctrl_ff;
      covered_in   = covered_ff;
      active_in    = active_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      res          = '0;
      retire       = 1'b0;

      // the user must write these registers only while idle; the block itself does not enforce it
      if (csr_wr_en) begin
         case (csr_index)
            oledvf_pkg::CSR_COLUMN_CMD: col_code_in  = csr_wdata;
            oledvf_pkg::CSR_PAGE_CMD:   page_code_in = csr_wdata;
            default: ;
         endcase
      end

      if (exec) begin
         case (cmd.op)
            oledvf_pkg::OP_ENQUEUE: begin
               if (found) begin
                  slot_win_in[free_idx] = cmd.win;
                  busy_in[free_idx]     = 1'b1;
               end else begin
                  res.enqueue_dropped = 1'b1;
               end
            end
            oledvf_pkg::OP_FAIL: begin
               retire = active_ff;
            end
            oledvf_pkg::OP_SLOT: begin
               if (active_ff) begin
                  if (covered_ff) begin
                     retire = 1'b1;
                  end else if (addr_ctrl_ff) begin
                     res.tx_valid = 1'b1;
                     res.tx_byte  = pending_ff;
                     res.hold_bus = 1'b1;
                     addr_ctrl_in = 1'b0;
                  end else begin
                     addr_ctrl_in = addr_hit;
                     // the sequencer may move on even without a byte to send
                     case (phase_ff)
                        PH_COL_MIN: begin
                           panel_in.min_col = w.min_col;
                           cur_col_in       = w.min_col;
                        end
                        PH_COL_MAX:  panel_in.max_col = w.max_col;
                        PH_PAGE_MIN: begin
                           panel_in.min_page = w.min_page;
                           cur_page_in       = w.min_page;
                        end
                        PH_PAGE_MAX: panel_in.max_page = w.max_page;
                        default: ;
                     endcase
                     if (addr_hit) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = oledvf_pkg::CTRL_CMD;
                        res.hold_bus = 1'b1;
                        pending_in   = addr_cmd;
                     end else if (!data_ctrl_ff) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = oledvf_pkg::CTRL_DATA;
                        res.hold_bus = 1'b1;
                        data_ctrl_in = 1'b1;
                     end else if (!cmd.pixel_avail) begin
                        retire = 1'b1;
                     end else begin
                        res.tx_valid      = 1'b1;
                        res.tx_byte       = cmd.pixel_byte;
                        res.hold_bus      = 1'b1;
                        res.byte_is_pixel = 1'b1;
                        res.pixel_col     = cur_col_ff;
                        res.pixel_page    = cur_page_ff;
                        // raster advance inside the panel window
                        if (cur_col_ff == panel_ff.max_col) begin
                           cur_col_in = panel_ff.min_col;
                           if (cur_page_ff == panel_ff.max_page) begin
                              cur_page_in = panel_ff.min_page;
                              covered_in  = 1'b1;
                           end else begin
                              cur_page_in = page_inc_tbl[cur_page_ff];
                           end
                        end else begin
                           cur_col_in = col_inc_tbl[cur_col_ff];
                        end
                     end
                  end
               end
            end
            default: ;
         endcase

         if (retire) begin
            res.req_finished = 1'b1;
            busy_in[head_ff] = 1'b0;
            head_in      = (head_ff == HW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            addr_ctrl_in = 1'b0;
            data_ctrl_in = 1'b0;
            covered_in   = 1'b0;
            active_in    = 1'b0;
         end

         // open a transfer when a request waits at the head
         if (!active_in && busy_in[head_in]) begin
            active_in          = 1'b1;
            res.start_transfer = 1'b1;
         end

         out_valid_in = 1'b1;
         out_item_in  = res;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // Sequencer phase moves only on a slot that reaches the address step, and returns to PH_NONE on retire
   logic      phase_step;
   phase_type phase_next;

   assign phase_step = exec && (cmd.op == oledvf_pkg::OP_SLOT) && active_ff &&
                       !covered_ff && !addr_ctrl_ff;
   always_comb begin
      phase_next = phase_ff;
      if (phase_step) begin
         phase_next = phase_in;
      end
      if (retire) begin
         phase_next = PH_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_code_ff  <= oledvf_pkg::COLUMN_CMD_RESET;
         page_code_ff <= oledvf_pkg::PAGE_CMD_RESET;
         busy_ff      <= '0;
         head_ff      <= '0;
         panel_ff.min_col  <= '0;
         panel_ff.max_col  <= CW'(NUM_COLUMNS - 1);
         panel_ff.min_page <= '0;
         panel_ff.max_page <= PGW'(NUM_PAGES - 1);
         cur_col_ff   <= '0;
         cur_page_ff  <= '0;
         phase_ff     <= PH_NONE;
         addr_ctrl_ff <= 1'b0;
         pending_ff   <= '0;
         data_ctrl_ff <= 1'b0;
         covered_ff   <= 1'b0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_code_ff  <= col_code_in;
         page_code_ff <= page_code_in;
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         panel_ff     <= panel_in;
         cur_col_ff   <= cur_col_in;
         cur_page_ff  <= cur_page_in;
         phase_ff     <= phase_next;
         addr_ctrl_ff <= addr_ctrl_in;
         pending_ff   <= pending_in;
         data_ctrl_ff <= data_ctrl_in;
         covered_ff   <= covered_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Slot windows and result payload carry no reset
   always_ff @(posedge clock) begin
      slot_win_ff <= slot_win_in;
      out_item_ff <= out_item_in;
   end

`ifndef SYNTHESIS
   a_active_has_busy_head: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> busy_ff[head_ff])
      else $error("open transfer without a busy head slot");

   a_covered_after_data: assert property (@(posedge clock) disable iff (reset)
      covered_ff |-> (data_ctrl_ff && active_ff))
      else $error("window covered before data control byte");

   a_addr_ctrl_in_transfer: assert property (@(posedge clock) disable iff (reset)
      addr_ctrl_ff |-> active_ff)
      else $error("address byte pending outside a transfer");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (exec && res.enqueue_dropped) |-> (&busy_ff))
      else $error("enqueue dropped with a free slot");

   a_finish_sends_nothing: assert property (@(posedge clock) disable iff (reset)
      exec |=> !(out_item_ff.req_finished && out_item_ff.tx_valid))
      else $error("retiring result also carries a byte");
`endif

endmodule

// ----- sv/oled_viewport_byte_framer.sv -----
// Top level of the OLED viewport byte framer: front, command queue and back.
// Path: an accepted item passes the front holding stage, the command queue and back
// execution, which writes its result into the result register on the rsp ports.
// Throughput: one item per cycle while results are popped; the back executes one
// queued command per cycle into a single result register.
// Reset: synchronous, active high; clears queues, slot busy bits, cursor and flags,
// sets the panel window to the full panel and the command codes to 33 and 34.
`timescale 1ns / 1ps

module oled_viewport_byte_framer #(
   parameter int QUEUE_DEPTH = 4,
   parameter int NUM_COLUMNS = 128,
   parameter int NUM_PAGES   = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  oledvf_pkg::req_item_type req_item,
   output logic                     empty,
   input  logic                     pop,
   output oledvf_pkg::rsp_item_type rsp_item,
   input  logic                     csr_wr_en,
   input  logic [oledvf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [oledvf_pkg::BYTE_W-1:0]    csr_wdata
);

   localparam int CMD_W = $bits(oledvf_pkg::cmd_type);

   oledvf_pkg::front_out_type front_out;
   oledvf_pkg::cmd_type       queue_head;
   logic                      queue_full;
   logic                      queue_not_empty;
   logic                      queue_pop;
   logic [CMD_W-1:0]          queue_data;

   oledvf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .to_queue   (front_out),
      .queue_full (queue_full)
   );

   oledvf_cmd_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (oledvf_pkg::CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (front_out.valid),
      .push_data (front_out.cmd),
      .full      (queue_full),
      .pop_en    (queue_pop),
      .pop_data  (queue_data),
      .not_empty (queue_not_empty)
   );

   assign queue_head = oledvf_pkg::cmd_type'(queue_data);

   oledvf_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_COLUMNS (NUM_COLUMNS),
      .NUM_PAGES   (NUM_PAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (queue_head),
      .cmd_pop   (queue_pop),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule
